>>> sv/id_range_overlap_registry_core_assert.svh
// ---------------------------------------------------------------------------
// id_range_overlap_registry_core_assert.svh
// assertion macros shared by the interval registry rtl
// ---------------------------------------------------------------------------
`ifndef ID_RANGE_OVERLAP_REGISTRY_CORE_ASSERT_SVH
`define ID_RANGE_OVERLAP_REGISTRY_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define IRO_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interval registry check failed");

// next-cycle implication, sampled on clk, off during reset
`define IRO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interval registry check failed");

`endif

>>> sv/iro_pkg.sv
// ---------------------------------------------------------------------------
// iro_pkg
// shared constants and types of the identifier interval registry
// ---------------------------------------------------------------------------
package iro_pkg;

	localparam int MAX_INTERVALS_DEF = 64;
	localparam int ID_BITS_DEF       = 14;

	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 2'd1;

	localparam int LOWEST_RST  = 1;
	localparam int HIGHEST_RST = 7999;

	typedef enum logic [STATUS_W-1:0] {
		ST_EMPTY      = 3'd0,
		ST_REGISTERED = 3'd1,
		ST_REVERSED   = 3'd2,
		ST_OUTSIDE    = 3'd3,
		ST_OVERLAP    = 3'd4,
		ST_FULL       = 3'd5
	} status_t;

endpackage

>>> sv/iro_table.sv
// ---------------------------------------------------------------------------
// iro_table
// interval storage: one write port, one registered read port
// ---------------------------------------------------------------------------
module iro_table #(
	parameter int MAX_INTERVALS = iro_pkg::MAX_INTERVALS_DEF,
	parameter int ID_BITS       = iro_pkg::ID_BITS_DEF,
	parameter int AW            = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [ID_BITS-1:0] wr_start,
	input  logic [ID_BITS:0]   wr_end,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [ID_BITS-1:0] rd_start,
	output logic [ID_BITS:0]   rd_end
);
	import iro_pkg::*;

	localparam int DW = 2 * ID_BITS + 1;

	logic [DW-1:0] mem [MAX_INTERVALS];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_start, wr_end};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_start = rd_data_q[DW-1:ID_BITS+1];
	assign rd_end   = rd_data_q[ID_BITS:0];

endmodule

>>> sv/iro_cmp.sv
// ---------------------------------------------------------------------------
// iro_cmp
// shared overlap compare unit, one stored interval per cycle
// ---------------------------------------------------------------------------
module iro_cmp #(
	parameter int ID_BITS = iro_pkg::ID_BITS_DEF
) (
	input  logic [ID_BITS-1:0] req_first,
	input  logic [ID_BITS:0]   req_last,
	input  logic [ID_BITS-1:0] ent_start,
	input  logic [ID_BITS:0]   ent_end,
	output logic               hit
);
	import iro_pkg::*;

	logic below;
	logic above;

	assign below = req_last < {1'b0, ent_start};
	assign above = {1'b0, req_first} > ent_end;
	assign hit   = !(below || above);

endmodule

>>> sv/id_range_overlap_registry_core.sv
// ---------------------------------------------------------------------------
// id_range_overlap_registry_core
// registry of claimed identifier intervals with overlap and limit checks
// ---------------------------------------------------------------------------
// usage:
//   a request transfers when start is high and busy is low; it carries
//   first_id and id_count. one result per request is shown on status and
//   entries_used for exactly one cycle, marked by done; the receiver cannot
//   stall, so it must take the result in that cycle.
//   empty, reversed and out-of-limit requests finish at once (done is
//   high in the cycle after the transfer). all others scan the stored
//   intervals through the single compare unit, one table read per cycle;
//   a hit ends the scan early.
//   busy is low again in the cycle that shows done, so a new request may
//   transfer while the previous result is on the ports.
//   cfg_we writes lowest (index 0) or highest (index 1) limit at once;
//   other indexes are ignored. write only while busy is low.
//   reset clears the entry count and restores the limits to 1 and 7999;
//   table contents are not cleared and are read only after being written.
// ---------------------------------------------------------------------------
module id_range_overlap_registry_core #(
	parameter int MAX_INTERVALS = iro_pkg::MAX_INTERVALS_DEF,
	parameter int ID_BITS       = iro_pkg::ID_BITS_DEF,
	parameter int CW            = $clog2(MAX_INTERVALS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iro_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ID_BITS-1:0]            cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic [ID_BITS-1:0]            first_id,
	input  logic [ID_BITS-1:0]            id_count,
	output logic                          done,
	output logic [iro_pkg::STATUS_W-1:0]  status,
	output logic [CW-1:0]                 entries_used
);
	import iro_pkg::*;

	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t               state_q;
	logic                 done_q;
	status_t              status_q;
	logic [CW-1:0]        entries_used_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic                 rd_vld_q;
	logic [ID_BITS-1:0]   lowest_q;
	logic [ID_BITS-1:0]   highest_q;
	logic [ID_BITS-1:0]   first_q;
	logic [ID_BITS:0]     last_q;

	logic [ID_BITS:0]     last_c;
	logic                 outside_c;
	logic                 issue;
	logic                 full;
	logic                 hit;
	logic                 wr_en;
	logic                 rd_en;
	logic [ID_BITS-1:0]   rd_start;
	logic [ID_BITS:0]     rd_end;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q  <= ID_BITS'(LOWEST_RST);
			highest_q <= ID_BITS'(HIGHEST_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWEST:  lowest_q  <= cfg_wdata;
				CFG_HIGHEST: highest_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// early checks on the incoming request
	assign last_c    = {1'b0, first_id} + {1'b0, id_count} - (ID_BITS + 1)'(1);
	assign outside_c = (first_id < lowest_q) || (last_c > {1'b0, highest_q});

	assign issue = (state_q == S_SCAN) && (idx_q < count_q);
	assign full  = (count_q == CW'(MAX_INTERVALS));
	assign rd_en = issue;
	assign wr_en = (state_q == S_SCAN) && !issue && !rd_vld_q && !full;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			first_q <= first_id;
			last_q  <= last_c;
		end
	end

	iro_table #(
		.MAX_INTERVALS(MAX_INTERVALS),
		.ID_BITS      (ID_BITS),
		.AW           (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_start(first_q),
		.wr_end  (last_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_start(rd_start),
		.rd_end  (rd_end)
	);

	iro_cmp #(
		.ID_BITS(ID_BITS)
	) u_cmp (
		.req_first(first_q),
		.req_last (last_q),
		.ent_start(rd_start),
		.ent_end  (rd_end),
		.hit      (hit)
	);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			done_q         <= 1'b0;
			status_q       <= ST_EMPTY;
			entries_used_q <= '0;
			count_q        <= '0;
			idx_q          <= '0;
			rd_vld_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q    <= '0;
						rd_vld_q <= 1'b0;
						if (first_id == '0 && id_count == '0) begin
							done_q         <= 1'b1;
							status_q       <= ST_EMPTY;
							entries_used_q <= count_q;
						end else if (id_count == '0) begin
							done_q         <= 1'b1;
							status_q       <= ST_REVERSED;
							entries_used_q <= count_q;
						end else if (outside_c) begin
							done_q         <= 1'b1;
							status_q       <= ST_OUTSIDE;
							entries_used_q <= count_q;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_vld_q <= issue;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_vld_q && hit) begin
						done_q         <= 1'b1;
						status_q       <= ST_OVERLAP;
						entries_used_q <= count_q;
						state_q        <= S_IDLE;
					end else if (!issue && !rd_vld_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (full) begin
							status_q       <= ST_FULL;
							entries_used_q <= count_q;
						end else begin
							status_q       <= ST_REGISTERED;
							count_q        <= count_q + CW'(1);
							entries_used_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign entries_used = entries_used_q;

`include "id_range_overlap_registry_core_assert.svh"

	`IRO_ASSERT_IMP(a_done_not_busy, done_q, !busy)
	`IRO_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_INTERVALS))
	`IRO_ASSERT_IMP(a_used_matches, done_q, entries_used_q == count_q)
	`IRO_ASSERT_NEXT(a_transfer_progress, start && !busy, busy || done_q)

endmodule
